[hw/rtl/ffba_pkg.sv]
// shared constants, codes and the request token for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MAX_BLOCKS   = 64;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned SUM_W  = SIZE_W + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request token walking the cell row
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [SIZE_W-1:0] req;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  rem;
    logic              append_ok;
    logic [ADDR_W-1:0] app_start;
    logic [ADDR_W-1:0] app_payload;
    logic              done;
    logic              appended;
    logic [1:0]        status;
    logic [ADDR_W-1:0] paddr;
  } tok_t;

endpackage

[hw/rtl/first_fit_block_allocator_top.sv]
// top level of the first-fit block allocator: launch, cell row, result words
// Each request word launches a token into a row of MAX_BLOCKS cells, one
// table entry per cell. The token moves one cell per cycle; the first live
// cell that matches (a free block large enough for an allocate, or the same
// payload offset for a free) acts on it, and the cell just past the last
// block appends a new block when nothing was reused. The result word
// reaches the output once the token has walked the whole cell row and
// passed the hold stage; the next request word is taken once the result
// has moved to the output register, so no new request is taken while one
// is in flight. The table needs no clearing after reset: only entries
// below the block count are ever looked at.
module first_fit_block_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [ffba_pkg::SIZE_W-1:0] req_size_i,
  input  logic [ffba_pkg::ADDR_W-1:0] free_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [ffba_pkg::ADDR_W-1:0] payload_addr_o
);

  // token chain: tok[0] is the launch register, tok[MAX_BLOCKS] the return
  ffba_pkg::tok_t tok [ffba_pkg::MAX_BLOCKS+1];
  ffba_pkg::tok_t launch_d;
  ffba_pkg::tok_t launch_q;
  ffba_pkg::tok_t ret;

  logic                        busy_q;
  logic [ffba_pkg::CNT_W-1:0]  count_q;
  logic [ffba_pkg::SIZE_W-1:0] end_q;     // start of the next appended block
  logic                        hold_v_q;
  logic [1:0]                  hold_status_q;
  logic [ffba_pkg::ADDR_W-1:0] hold_addr_q;
  logic                        out_v_q;
  logic [1:0]                  out_status_q;
  logic [ffba_pkg::ADDR_W-1:0] out_addr_q;

  logic                        in_acc;
  logic                        out_free;
  logic [ffba_pkg::SUM_W-1:0]  payload;
  logic [ffba_pkg::SUM_W:0]    payload_end;
  logic                        oversize;
  logic [1:0]                  ret_status;
  logic [ffba_pkg::MAX_BLOCKS:0] tok_valids;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign out_free   = !out_v_q || !out_stall_i;

  // append bookkeeping, worked out once at launch
  assign payload     = {1'b0, end_q} + ffba_pkg::SUM_W'(ffba_pkg::HEADER_BYTES);
  assign payload_end = {1'b0, payload} + (ffba_pkg::SUM_W+1)'(req_size_i);
  assign oversize    = ((ffba_pkg::SUM_W)'(ffba_pkg::HEADER_BYTES) + {1'b0, req_size_i})
                       > ffba_pkg::SUM_W'(ffba_pkg::POOL_BYTES);

  always_comb begin
    launch_d             = '0;
    launch_d.valid       = in_acc;
    launch_d.cmd         = cmd_i;
    launch_d.req         = req_size_i;
    launch_d.addr        = free_addr_i;
    launch_d.rem         = count_q;
    launch_d.append_ok   = (payload < ffba_pkg::SUM_W'(ffba_pkg::POOL_BYTES)) &&
                           (payload_end <= (ffba_pkg::SUM_W+1)'(ffba_pkg::POOL_BYTES));
    launch_d.app_start   = end_q[ffba_pkg::ADDR_W-1:0];
    launch_d.app_payload = payload[ffba_pkg::ADDR_W-1:0];
    // oversize allocate is settled before the walk
    if (cmd_i == ffba_pkg::CMD_ALLOC && oversize) begin
      launch_d.done   = 1'b1;
      launch_d.status = ffba_pkg::ST_NOMEM;
    end
  end

  assign tok[0] = launch_q;

  // the row of table cells
  for (genvar g = 0; g < ffba_pkg::MAX_BLOCKS; g++) begin : g_cell
    ffba_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  assign ret = tok[ffba_pkg::MAX_BLOCKS];

  // status of the returning token: its own when done, else no room in the table or unknown free address
  always_comb begin
    if (ret.done) begin
      ret_status = ret.status;
    end else if (ret.cmd == ffba_pkg::CMD_ALLOC) begin
      ret_status = ffba_pkg::ST_FULL;
    end else begin
      ret_status = ffba_pkg::ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
      busy_q   <= 1'b0;
      count_q  <= '0;
      end_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      launch_q <= launch_d;
      if (in_acc) begin
        busy_q <= 1'b1;
      end
      if (ret.valid) begin
        hold_v_q <= 1'b1;
        if (ret.appended) begin
          count_q <= count_q + 1'b1;
          end_q   <= ffba_pkg::SIZE_W'(ret.app_payload) + ret.req;
        end
      end
      // result leaves the hold stage for the output register
      if (hold_v_q && out_free) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
        busy_q   <= 1'b0;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ret.valid) begin
      hold_status_q <= ret_status;
      hold_addr_q   <= ret.done ? ret.paddr : '0;
    end
    if (hold_v_q && out_free) begin
      out_status_q <= hold_status_q;
      out_addr_q   <= hold_addr_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = out_status_q;
  assign payload_addr_o = out_addr_q;

  for (genvar g = 0; g <= ffba_pkg::MAX_BLOCKS; g++) begin : g_vld
    assign tok_valids[g] = tok[g].valid;
  end

`ifndef ASSERT_OFF
  // only one request is ever in the cell row
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valids))
    else $error("more than one token in the cell row");

  // a returning token never finds the hold stage occupied
  a_hold_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret.valid |-> !hold_v_q)
    else $error("result collision at the hold stage");

  // the block count stays within the table
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
    else $error("block count past table size");

  // a token is in flight only while busy and nothing is held
  a_busy_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valids != '0) |-> busy_q && !hold_v_q)
    else $error("token walking while not busy");
`endif

endmodule

[hw/rtl/ffba_cell.sv]
// one table entry of the allocator and its token stage
module ffba_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffba_pkg::tok_t tok_i,
  output ffba_pkg::tok_t tok_o
);

  logic [ffba_pkg::ADDR_W-1:0] start_q, start_d;
  logic [ffba_pkg::SIZE_W-1:0] len_q, len_d;
  logic                        used_q, used_d;
  ffba_pkg::tok_t              tok_q, tok_d;

  logic                        live;
  logic [ffba_pkg::SIZE_W-1:0] hdr_addr;

  assign live     = (tok_i.rem != '0);
  assign hdr_addr = {1'b0, start_q} + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES);

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    used_d  = used_q;
    tok_d   = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (live) begin
        tok_d.rem = tok_i.rem - 1'b1;
        if (tok_i.cmd == ffba_pkg::CMD_FREE) begin
          if (hdr_addr == {1'b0, tok_i.addr}) begin
            used_d       = 1'b0;
            tok_d.done   = 1'b1;
            tok_d.status = ffba_pkg::ST_OK;
            tok_d.paddr  = '0;
          end
        end else if (!used_q && (tok_i.req <= len_q)) begin
          used_d       = 1'b1;
          tok_d.done   = 1'b1;
          tok_d.status = ffba_pkg::ST_OK;
          tok_d.paddr  = hdr_addr[ffba_pkg::ADDR_W-1:0];
        end
      end else if (tok_i.cmd == ffba_pkg::CMD_ALLOC) begin
        // first unused slot: append here or give up
        tok_d.done = 1'b1;
        if (tok_i.append_ok) begin
          start_d        = tok_i.app_start;
          len_d          = tok_i.req;
          used_d         = 1'b1;
          tok_d.appended = 1'b1;
          tok_d.status   = ffba_pkg::ST_OK;
          tok_d.paddr    = tok_i.app_payload;
        end else begin
          tok_d.status = ffba_pkg::ST_NOMEM;
          tok_d.paddr  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    used_q  <= used_d;
  end

  assign tok_o = tok_q;

endmodule

[dv/first_fit_block_allocator_top_tb.sv]
// self-checking testbench for the first-fit block allocator top level
`timescale 1ns / 1ps

module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  // run bounds: a request walks the whole cell row, so allow generous room
  localparam int unsigned ROW_CYCLES  = MAX_BLOCKS + 3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned SMALL_LEN   = 40;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              cmd_i = CMD_ALLOC;
  logic [SIZE_W-1:0] req_size_i = '0;
  logic [ADDR_W-1:0] free_addr_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] payload_addr_o;

  // shadow copy of the block table, only entries below pool_blocks are live
  int unsigned pool_start [MAX_BLOCKS];
  int unsigned pool_len   [MAX_BLOCKS];
  bit          pool_used  [MAX_BLOCKS];
  int unsigned pool_blocks = 0;

  // answers owed by the block, oldest first
  result_t     awaited_results [$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;
  // when set, neither side idles or stalls
  bit          calm = 1'b0;

  first_fit_block_allocator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .req_size_i     (req_size_i),
    .free_addr_i    (free_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .payload_addr_o (payload_addr_o)
  );

  always #1 clk_i = ~clk_i;

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited", $time,
               cycle_count, awaited_results.size());
      $display("first_fit_block_allocator_top_tb: FAIL");
      $finish;
    end
  end

  // receiver back-pressure, random unless in a calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // first-fit table update for one request, returns the answer it must give
  function automatic result_t alloc_outcome(logic cmd, logic [SIZE_W-1:0] size,
                                            logic [ADDR_W-1:0] addr);
    result_t     res;
    bit          hit;
    int unsigned start;
    int unsigned payload;
    res.status = ST_OK;
    res.addr   = '0;
    hit        = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (HEADER_BYTES + size > POOL_BYTES) begin
        // larger than the pool can ever hold
        res.status = ST_NOMEM;
      end else begin
        // first unused block big enough, kept at its original size
        for (int i = 0; i < pool_blocks; i++) begin
          if (!hit && !pool_used[i] && size <= pool_len[i]) begin
            hit          = 1'b1;
            pool_used[i] = 1'b1;
            res.addr     = ADDR_W'(pool_start[i] + HEADER_BYTES);
          end
        end
        if (!hit) begin
          if (pool_blocks >= MAX_BLOCKS) begin
            res.status = ST_FULL;
          end else begin
            // append right behind the last block
            start = (pool_blocks == 0) ? 0 :
                    pool_start[pool_blocks-1] + HEADER_BYTES + pool_len[pool_blocks-1];
            payload = start + HEADER_BYTES;
            if (payload >= POOL_BYTES || payload + size > POOL_BYTES) begin
              res.status = ST_NOMEM;
            end else begin
              pool_start[pool_blocks] = start;
              pool_len[pool_blocks]   = size;
              pool_used[pool_blocks]  = 1'b1;
              pool_blocks++;
              res.addr = ADDR_W'(payload);
            end
          end
        end
      end
    end else begin
      // free by payload offset; freeing an unused block again is fine
      res.status = ST_UNKNOWN;
      for (int i = 0; i < pool_blocks; i++) begin
        if (!hit && pool_start[i] + HEADER_BYTES == addr) begin
          hit          = 1'b1;
          pool_used[i] = 1'b0;
          res.status   = ST_OK;
        end
      end
    end
    return res;
  endfunction

  // present one request word and wait until the block takes it
  task automatic issue_request(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    // random gap before the word; valid stays high when there is none
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    req_size_i  <= size;
    free_addr_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(alloc_outcome(cmd, size, addr));
    requests_sent++;
  endtask

  // one random request: mostly frees of live blocks and small allocations,
  // some oversize requests, appends that run past the pool end, stray frees
  task automatic random_request(int unsigned max_len);
    int unsigned pick;
    int unsigned next_payload;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (pool_blocks != 0 && $urandom_range(0, 4) != 0)
        addr = ADDR_W'(pool_start[$urandom_range(0, pool_blocks - 1)] + HEADER_BYTES);
      else
        addr = ADDR_W'($urandom);
      issue_request(CMD_FREE, SIZE_W'($urandom), addr);
    end else begin
      if (pick < 90) begin
        size = SIZE_W'($urandom_range(0, max_len));
      end else if (pick < 95 || pool_blocks == 0) begin
        size = SIZE_W'($urandom_range(POOL_BYTES - HEADER_BYTES + 1, (1 << SIZE_W) - 1));
      end else begin
        // fits the pool on its own but not behind the last block
        next_payload = pool_start[pool_blocks-1] + pool_len[pool_blocks-1] + 2 * HEADER_BYTES;
        size = SIZE_W'($urandom_range(POOL_BYTES + 1 - next_payload,
                                      POOL_BYTES - HEADER_BYTES));
      end
      issue_request(CMD_ALLOC, size, ADDR_W'($urandom));
    end
  endtask

  // hand-picked corners on an empty table
  task automatic test_directed_cases();
    // frees before any block exists
    issue_request(CMD_FREE, '0, '0);
    issue_request(CMD_FREE, '1, '1);
    // oversize, the widest size and just past the header limit
    issue_request(CMD_ALLOC, '1, '0);
    issue_request(CMD_ALLOC, SIZE_W'(POOL_BYTES - HEADER_BYTES + 1), '1);
    issue_request(CMD_ALLOC, SIZE_W'(POOL_BYTES), '0);
    // zero-size blocks get appended
    issue_request(CMD_ALLOC, '0, '1);
    issue_request(CMD_ALLOC, '0, '0);
    // free, then double free, then an offset that is off by one
    issue_request(CMD_FREE, '0, ADDR_W'(HEADER_BYTES));
    issue_request(CMD_FREE, '1, ADDR_W'(HEADER_BYTES));
    issue_request(CMD_FREE, '0, ADDR_W'(HEADER_BYTES + 1));
    // too big for the freed empty block, so a new one
    issue_request(CMD_ALLOC, SIZE_W'(1), '0);
    // zero size takes the freed empty block
    issue_request(CMD_ALLOC, '0, '0);
    // largest legal size, but the append runs past the pool end
    issue_request(CMD_ALLOC, SIZE_W'(POOL_BYTES - HEADER_BYTES), '1);
    // free the one-byte block and reuse it without a split
    issue_request(CMD_FREE, '0, ADDR_W'(3 * HEADER_BYTES));
    issue_request(CMD_ALLOC, '0, '0);
    issue_request(CMD_ALLOC, SIZE_W'(SMALL_LEN), '0);
    issue_request(CMD_FREE, '0, ADDR_W'(2 * HEADER_BYTES));
    issue_request(CMD_ALLOC, SIZE_W'(1), '1);
  endtask

  // mixed traffic while the table still grows
  task automatic test_mixed_traffic(int unsigned count);
    repeat (count) random_request(SMALL_LEN);
  endtask

  // fill every table slot, then ask for more, all without idling
  task automatic test_table_full();
    calm = 1'b1;
    while (pool_blocks < MAX_BLOCKS)
      issue_request(CMD_ALLOC, SIZE_W'($urandom_range(0, SMALL_LEN)), ADDR_W'($urandom));
    // nothing free fits these
    issue_request(CMD_ALLOC, SIZE_W'(POOL_BYTES - HEADER_BYTES), '0);
    issue_request(CMD_ALLOC, SIZE_W'(SMALL_LEN + 1), '1);
    // a freed slot is found even at the far end of the row
    issue_request(CMD_FREE, '0, ADDR_W'(pool_start[MAX_BLOCKS-1] + HEADER_BYTES));
    issue_request(CMD_ALLOC, '0, '0);
    issue_request(CMD_ALLOC, '0, '0);
    calm = 1'b0;
  endtask

  // first-fit search across a full row of mixed sizes
  task automatic test_full_table_traffic(int unsigned count);
    repeat (count) random_request(SMALL_LEN + 8);
  endtask

  // compare every accepted result word with the oldest awaited answer
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d payload_addr %0d", $time,
                 status_o, payload_addr_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        status_hits[want.status]++;
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatches++;
        end
        if (payload_addr_o !== want.addr) begin
          $display("%0t: payload_addr expected %0d actual %0d", $time, want.addr,
                   payload_addr_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_mixed_traffic(250);
    test_table_full();
    test_full_table_traffic(200);

    in_valid_i <= 1'b0;
    // drain, then watch a while longer for stray words
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2 * ROW_CYCLES) @(posedge clk_i);

    $display("ran %0d requests, %0d blocks in the table at the end", requests_sent,
             pool_blocks);
    $display("results: %0d ok, %0d out of memory, %0d unknown address, %0d table full",
             status_hits[ST_OK], status_hits[ST_NOMEM], status_hits[ST_UNKNOWN],
             status_hits[ST_FULL]);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_top_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
